// File: hdl/row_column_remap_table_macros.svh
// Assertion macros for the row/column remap table checker.
// Needs nothing else; included by files that assert.
`ifndef ROW_COLUMN_REMAP_TABLE_MACROS_SVH
`define ROW_COLUMN_REMAP_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rcrt_pkg.sv
// Shared constants, types and helpers for the row/column remap table.
// No dependencies.
`timescale 1ns / 1ps

package rcrt_pkg;

  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned MAX_COLS   = 1024;
  localparam int unsigned VALUE_BITS = 20;

  // Fixed port widths.
  localparam int unsigned IDX_BITS  = 10;
  localparam int unsigned LOAD_BITS = 20;
  localparam int unsigned OUT_BITS  = 20;

  localparam int unsigned ROW_BITS  = $clog2(MAX_ROWS);
  localparam int unsigned COL_BITS  = $clog2(MAX_COLS);
  localparam int unsigned MAX_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned CLR_BITS  = $clog2(MAX_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_SWAP_ROWS = 2'd1,
    OP_SWAP_COLS = 2'd2,
    OP_GET       = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWAP_FIRST,
    ST_SWAP_SECOND,
    ST_GET_MAP,
    ST_GET_CELL
  } state_t;

  function automatic logic below(input logic [IDX_BITS-1:0] idx, input int unsigned lim);
    return 32'(idx) < lim;
  endfunction

endpackage

// File: hdl/rcrt_map_ram.sv
// Generic RAM: one write port, two registered read ports.
// Used for the row and column maps; no dependencies.
`timescale 1ns / 1ps

module rcrt_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/row_column_remap_table.sv
// Top level of the row/column remap table: control FSM, cell store, output register.
// Depends on rcrt_pkg and rcrt_map_ram.
`timescale 1ns / 1ps

// Cell store reached through a row map and a column map, both reset to identity.
// After reset a clearing pass writes the identity into both maps, walking
// max(MAX_ROWS, MAX_COLS) entries with in_stall high. Then one request is
// worked at a time: a load is a direct write to the cell store; a swap reads
// both map entries together, then writes them back one at a time through the
// map's single write port; a get does a map read, then a cell read, then an
// output load, which waits until the output register is free.
// A finished result waits in the output register while the next request is taken.
module row_column_remap_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rcrt_pkg::opcode_t                opcode,
  input  logic [rcrt_pkg::IDX_BITS-1:0]    first_index,
  input  logic [rcrt_pkg::IDX_BITS-1:0]    second_index,
  input  logic [rcrt_pkg::LOAD_BITS-1:0]   load_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rcrt_pkg::OUT_BITS-1:0]    cell_value
);

  import rcrt_pkg::*;

  state_t state, state_next;
  logic [CLR_BITS-1:0] clr_cnt;

  opcode_t             op_q;
  logic [IDX_BITS-1:0] idx_a, idx_b;
  logic                range_ok;
  logic                range_ok_next;

  logic accept;
  logic out_load;
  logic cell_re;

  logic                row_we, col_we;
  logic [ROW_BITS-1:0] row_waddr, row_wdata, row_rd_a, row_rd_b;
  logic [COL_BITS-1:0] col_waddr, col_wdata, col_rd_a, col_rd_b;

  logic [VALUE_BITS-1:0] cell_mem [MAX_ROWS][MAX_COLS];
  logic [VALUE_BITS-1:0] cell_rd;

  // ---- maps ----
  rcrt_map_ram #(.DEPTH(MAX_ROWS), .WIDTH(ROW_BITS)) u_row_map (
    .clk     (clk),
    .we      (row_we),
    .waddr   (row_waddr),
    .wdata   (row_wdata),
    .re      (accept),
    .raddr_a (ROW_BITS'(first_index)),
    .raddr_b (ROW_BITS'(second_index)),
    .rdata_a (row_rd_a),
    .rdata_b (row_rd_b)
  );

  rcrt_map_ram #(.DEPTH(MAX_COLS), .WIDTH(COL_BITS)) u_col_map (
    .clk     (clk),
    .we      (col_we),
    .waddr   (col_waddr),
    .wdata   (col_wdata),
    .re      (accept),
    .raddr_a (COL_BITS'(second_index)),
    .raddr_b (COL_BITS'(first_index)),
    .rdata_a (col_rd_a),
    .rdata_b (col_rd_b)
  );

  // ---- request range check ----
  always_comb begin
    unique case (opcode)
      OP_LOAD:      range_ok_next = below(first_index, MAX_ROWS) &&
                                    below(second_index, MAX_COLS);
      OP_SWAP_ROWS: range_ok_next = below(first_index, MAX_ROWS) &&
                                    below(second_index, MAX_ROWS);
      OP_SWAP_COLS: range_ok_next = below(first_index, MAX_COLS) &&
                                    below(second_index, MAX_COLS);
      OP_GET:       range_ok_next = below(first_index, MAX_ROWS) &&
                                    below(second_index, MAX_COLS);
      default:      range_ok_next = 1'b0;
    endcase
  end

  // ---- FSM: next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_BITS'(MAX_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_LOAD:      state_next = ST_IDLE;
            OP_SWAP_ROWS: state_next = ST_SWAP_FIRST;
            OP_SWAP_COLS: state_next = ST_SWAP_FIRST;
            OP_GET:       state_next = ST_GET_MAP;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWAP_FIRST:  state_next = ST_SWAP_SECOND;
      ST_SWAP_SECOND: state_next = ST_IDLE;
      ST_GET_MAP:     state_next = ST_GET_CELL;
      ST_GET_CELL: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // ---- FSM: outputs ----
  // Column map read port a holds the entry at second_index, port b the one at first_index.
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    cell_re   = 1'b0;
    out_load  = 1'b0;
    row_we    = 1'b0;
    row_waddr = ROW_BITS'(idx_a);
    row_wdata = row_rd_b;
    col_we    = 1'b0;
    col_waddr = COL_BITS'(idx_a);
    col_wdata = col_rd_a;
    unique case (state)
      ST_CLEAR: begin
        row_we    = 32'(clr_cnt) < MAX_ROWS;
        row_waddr = ROW_BITS'(clr_cnt);
        row_wdata = ROW_BITS'(clr_cnt);
        col_we    = 32'(clr_cnt) < MAX_COLS;
        col_waddr = COL_BITS'(clr_cnt);
        col_wdata = COL_BITS'(clr_cnt);
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      // first write: map[a] <= old map[b]
      ST_SWAP_FIRST: begin
        row_we = range_ok && (op_q == OP_SWAP_ROWS);
        col_we = range_ok && (op_q == OP_SWAP_COLS);
      end
      // second write: map[b] <= old map[a]
      ST_SWAP_SECOND: begin
        row_we    = range_ok && (op_q == OP_SWAP_ROWS);
        row_waddr = ROW_BITS'(idx_b);
        row_wdata = row_rd_a;
        col_we    = range_ok && (op_q == OP_SWAP_COLS);
        col_waddr = COL_BITS'(idx_b);
        col_wdata = col_rd_b;
      end
      ST_GET_MAP: begin
        cell_re = range_ok;
      end
      ST_GET_CELL: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + CLR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= opcode;
      idx_a    <= first_index;
      idx_b    <= second_index;
      range_ok <= range_ok_next;
    end
  end

  // ---- cell store ----
  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_LOAD) && range_ok_next) begin
      cell_mem[ROW_BITS'(first_index)][COL_BITS'(second_index)] <=
        VALUE_BITS'(load_value);
    end
  end

  always_ff @(posedge clk) begin
    if (cell_re) begin
      cell_rd <= cell_mem[row_rd_a][col_rd_a];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_value <= range_ok ? OUT_BITS'(cell_rd) : '0;
    end
  end

endmodule

// File: hdl/rcrt_checker.sv
// Port-level checker for the row/column remap table, bound to the top level.
// Depends on rcrt_pkg and row_column_remap_table_macros.svh.
`timescale 1ns / 1ps
`include "row_column_remap_table_macros.svh"

module rcrt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input rcrt_pkg::opcode_t              opcode,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rcrt_pkg::OUT_BITS-1:0]  cell_value
);

  import rcrt_pkg::*;

  // clearing pass holds off requests right after reset
  `RCRT_ASSERT_NOW(a_clear_after_reset, clk, rst, $past(rst), in_stall, "request taken during map clear")

  // swaps and gets hold off the next request once taken
  `RCRT_ASSERT_NEXT(a_multi_cycle_busy, clk, rst, in_valid && !in_stall && opcode != OP_LOAD, in_stall, "swap or get did not hold off the next request")

  // a new result only comes out of get processing
  `RCRT_ASSERT_NOW(a_result_from_get, clk, rst, $rose(out_valid), $past(in_stall), "result appeared without a get in progress")

  `RCRT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cell_value), "stalled result changed")

endmodule

bind row_column_remap_table rcrt_checker u_rcrt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .opcode     (opcode),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .cell_value (cell_value)
);
